// File: design/sdmb_pkg.sv
// Shared constants, codes and types of the serial debug memory bridge.
package sdmb_pkg;

   // Frame and window sizes
   localparam int MAX_FRAME = 29;
   localparam int MAX_READ = 27;
   localparam int WIN_BYTES = 4096;

   localparam int WIN_AW = $clog2(WIN_BYTES);
   localparam int FRAME_AW = $clog2(MAX_FRAME);
   localparam int LEN_W = $clog2(MAX_FRAME + 1);
   localparam int IDX_MAX = (MAX_READ > MAX_FRAME) ? MAX_READ : MAX_FRAME;
   localparam int IDX_W = $clog2(IDX_MAX + 1);

   // Reset values of the configuration registers
   localparam logic [31:0] RESET_BASE = 32'h2000_0000;
   localparam logic [7:0] RESET_HEADER = 8'hDB;

   // Byte positions inside a frame
   localparam int LEN_AT = 1;
   localparam int CMD_AT = 2;
   localparam int BODY_AT = 3;
   localparam int BODY_BYTES = 5;
   localparam int DATA_AT = 7;
   localparam int MIN_LEN = 3;
   localparam int READ_MIN_LEN = 8;
   localparam int REPLY_HDR_LEN = 3;

   // Commands
   localparam logic [7:0] CMD_READ = 8'd0;
   localparam logic [7:0] CMD_WRITE = 8'd1;
   localparam logic [7:0] CMD_RESET = 8'd2;

   // Result kinds
   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_WINDOW_BASE = 1'b0,
      CSR_HEADER_BYTE = 1'b1
   } csr_index_type;

   // Fields of a collected frame
   typedef struct packed {
      logic [7:0] cmd;
      logic [LEN_W-1:0] len;
      logic [7:0] cnt;
      logic [31:0] waddr;
      logic [31:0] raddr;
   } frame_type;

endpackage

// File: design/sdmb_rx.sv
// Frame receiver: header hunt, field capture and the frame byte buffer.
module sdmb_rx (
   input logic clock,
   input logic reset,
   input logic in_fire,
   input logic [7:0] in_byte,
   input logic [7:0] header_byte,
   input logic [sdmb_pkg::FRAME_AW-1:0] rd_addr,
   output logic done,
   output sdmb_pkg::frame_type frame,
   output logic [7:0] rd_data
);
   import sdmb_pkg::*;

   logic col_ff, col_in;
   logic [FRAME_AW-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] body_ff [BODY_BYTES];
   logic [7:0] body_in [BODY_BYTES];
   logic done_ff, done_in;
   logic buf_we;
   logic [7:0] buf_mem [MAX_FRAME];
   logic [7:0] rd_data_ff;

   always_comb begin
      col_in = col_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      cmd_in = cmd_ff;
      body_in = body_ff;
      done_in = 1'b0;
      buf_we = 1'b0;
      if (in_fire) begin
         if (!col_ff) begin
            if (in_byte == header_byte) begin
               col_in = 1'b1;
               cnt_in = FRAME_AW'(1);
            end
         end else begin
            buf_we = 1'b1;
            if (cnt_ff == FRAME_AW'(LEN_AT)) begin
               if (in_byte < 8'(MIN_LEN) || in_byte > 8'(MAX_FRAME)) begin
                  col_in = 1'b0;
                  cnt_in = '0;
               end else begin
                  len_in = LEN_W'(in_byte);
                  cnt_in = cnt_ff + FRAME_AW'(1);
               end
            end else begin
               if (cnt_ff == FRAME_AW'(CMD_AT))
                  cmd_in = in_byte;
               for (int k = 0; k < BODY_BYTES; k++) begin
                  if (cnt_ff == FRAME_AW'(BODY_AT + k))
                     body_in[k] = in_byte;
               end
               if (LEN_W'(cnt_ff) + LEN_W'(1) >= len_ff) begin
                  done_in = 1'b1;
                  col_in = 1'b0;
                  cnt_in = '0;
               end else begin
                  cnt_in = cnt_ff + FRAME_AW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      len_ff <= len_in;
      cmd_ff <= cmd_in;
      body_ff <= body_in;
   end

   // Frame buffer, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (buf_we)
         buf_mem[cnt_ff] <= in_byte;
      rd_data_ff <= buf_mem[rd_addr];
   end

   assign done = done_ff;
   assign rd_data = rd_data_ff;
   assign frame.cmd = cmd_ff;
   assign frame.len = len_ff;
   assign frame.cnt = body_ff[0];
   assign frame.waddr = {body_ff[3], body_ff[2], body_ff[1], body_ff[0]};
   assign frame.raddr = {body_ff[4], body_ff[3], body_ff[2], body_ff[1]};

endmodule

// File: design/serial_debug_memory_bridge.sv
// Top level of the serial debug memory bridge.
// Takes one received byte per req transaction and answers completed frames on rsp.
// After reset the block zeroes all WIN_BYTES (4096) bytes of its window memory and
// accepts no byte meanwhile; configuration writes are taken at any time. Input is also
// held off while a completed frame is decoded and while its reply or write is under way.
// A read frame emits three header bytes, then for each data byte (up to 27) a memory read
// and then an output register load, stalling on the output; a write frame walks its data
// bytes as a frame buffer read, then a window write; a reset request emits one reset-kind
// byte.
module serial_debug_memory_bridge (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata,        // [7:0] rx_byte
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [7:0] rsp_tdata,       // [7:0] tx_byte
   output logic rsp_tuser,             // [0] kind
   output logic rsp_tlast,
   input logic csr_valid,
   output logic csr_ready,
   input sdmb_pkg::csr_index_type csr_index,
   input logic [31:0] csr_data
);
   import sdmb_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE = 8'b0000_0010,
      ST_HEAD = 8'b0000_0100,
      ST_RFETCH = 8'b0000_1000,
      ST_RSEND = 8'b0001_0000,
      ST_WFETCH = 8'b0010_0000,
      ST_WSTORE = 8'b0100_0000,
      ST_RST = 8'b1000_0000
   } state_type;

   localparam int HEAD_LAST_STEP = REPLY_HDR_LEN - 1;

   state_type state_ff, state_in;
   logic [31:0] base_ff;
   logic [7:0] hdr_ff;
   logic [WIN_AW-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] nwr_ff, nwr_in;
   logic [31:0] cur_ff, cur_in;
   logic win_ff, win_in;
   logic [WIN_AW-1:0] off_ff, off_in;

   logic rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic rsp_user_ff, rsp_last_ff;
   logic rsp_free, load;
   logic [7:0] ld_data;
   logic ld_user, ld_last;

   logic [31:0] rel_addr;
   logic rel_in_win;
   logic t_we, t_re;
   logic [WIN_AW-1:0] t_wa;
   logic [7:0] t_wd;
   logic [7:0] tmem [WIN_BYTES];
   logic [7:0] t_q;

   logic frm_done;
   frame_type frm;
   logic [7:0] frm_q;
   logic [FRAME_AW-1:0] frm_ra;
   logic req_fire;

   assign req_fire = req_tvalid && req_tready;
   assign frm_ra = FRAME_AW'(DATA_AT) + FRAME_AW'(idx_ff);

   sdmb_rx u_rx (
      .clock(clock),
      .reset(reset),
      .in_fire(req_fire),
      .in_byte(req_tdata),
      .header_byte(hdr_ff),
      .rd_addr(frm_ra),
      .done(frm_done),
      .frame(frm),
      .rd_data(frm_q)
   );

   // Window test: offset from the base wraps mod 2^32, upper bound exclusive
   assign rel_addr = cur_ff - base_ff;
   assign rel_in_win = rel_addr < 32'(WIN_BYTES);

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      nwr_in = nwr_ff;
      cur_in = cur_ff;
      win_in = win_ff;
      off_in = off_ff;
      load = 1'b0;
      ld_data = 8'd0;
      ld_user = KIND_TX;
      ld_last = 1'b0;
      t_we = 1'b0;
      t_re = 1'b0;
      t_wa = clr_ff;
      t_wd = 8'd0;
      case (state_ff)
         ST_CLEAR: begin
            t_we = 1'b1;
            clr_in = clr_ff + WIN_AW'(1);
            if (clr_ff == WIN_AW'(WIN_BYTES - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (frm_done) begin
               idx_in = '0;
               case (frm.cmd)
                  CMD_READ: begin
                     if (frm.len >= LEN_W'(READ_MIN_LEN)) begin
                        if (frm.cnt > 8'(MAX_READ))
                           cnt_in = IDX_W'(MAX_READ);
                        else
                           cnt_in = IDX_W'(frm.cnt);
                        cur_in = frm.raddr;
                        state_in = ST_HEAD;
                     end
                  end
                  CMD_WRITE: begin
                     if (frm.len > LEN_W'(DATA_AT)) begin
                        nwr_in = IDX_W'(frm.len - LEN_W'(DATA_AT));
                        cur_in = frm.waddr;
                        state_in = ST_WFETCH;
                     end
                  end
                  CMD_RESET: state_in = ST_RST;
                  default: ;
               endcase
            end
         end
         ST_HEAD: begin
            if (rsp_free) begin
               load = 1'b1;
               case (idx_ff)
                  IDX_W'(0): ld_data = hdr_ff;
                  IDX_W'(1): ld_data = 8'(cnt_ff) + 8'(REPLY_HDR_LEN);
                  default: begin
                     ld_data = 8'd0;
                     ld_last = (cnt_ff == '0);
                  end
               endcase
               idx_in = idx_ff + IDX_W'(1);
               if (idx_ff == IDX_W'(HEAD_LAST_STEP)) begin
                  idx_in = '0;
                  state_in = (cnt_ff == '0) ? ST_IDLE : ST_RFETCH;
               end
            end
         end
         ST_RFETCH: begin
            t_re = 1'b1;
            win_in = rel_in_win;
            state_in = ST_RSEND;
         end
         ST_RSEND: begin
            if (rsp_free) begin
               load = 1'b1;
               ld_data = win_ff ? t_q : 8'd0;
               ld_last = (idx_ff + IDX_W'(1) == cnt_ff);
               idx_in = idx_ff + IDX_W'(1);
               cur_in = cur_ff + 32'd1;
               state_in = ld_last ? ST_IDLE : ST_RFETCH;
            end
         end
         ST_WFETCH: begin
            win_in = rel_in_win;
            off_in = rel_addr[WIN_AW-1:0];
            state_in = ST_WSTORE;
         end
         ST_WSTORE: begin
            t_we = win_ff;
            t_wa = off_ff;
            t_wd = frm_q;
            idx_in = idx_ff + IDX_W'(1);
            cur_in = cur_ff + 32'd1;
            state_in = (idx_ff + IDX_W'(1) == nwr_ff) ? ST_IDLE : ST_WFETCH;
         end
         ST_RST: begin
            if (rsp_free) begin
               load = 1'b1;
               ld_user = KIND_RESET;
               ld_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff <= RESET_BASE;
         hdr_ff <= RESET_HEADER;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         idx_ff <= idx_in;
         if (load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_BASE: base_ff <= csr_data;
               CSR_HEADER_BYTE: hdr_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
      cnt_ff <= cnt_in;
      nwr_ff <= nwr_in;
      cur_ff <= cur_in;
      win_ff <= win_in;
      off_ff <= off_in;
      if (load) begin
         rsp_data_ff <= ld_data;
         rsp_user_ff <= ld_user;
         rsp_last_ff <= ld_last;
      end
   end

   // Window memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (t_we)
         tmem[t_wa] <= t_wd;
      if (t_re)
         t_q <= tmem[rel_addr[WIN_AW-1:0]];
   end

   assign req_tready = (state_ff == ST_IDLE) && !frm_done;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

// File: design/sdmb_checker.sv
// Port-level checks of the serial debug memory bridge, bound to the top level.
module sdmb_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic rsp_tuser,
   input logic rsp_tlast
);
   import sdmb_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // Window clear blocks input right after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input accepted during window clear");

   // Reset request is a single zero byte closing its run
   a_reset_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_RESET |-> rsp_tdata == 8'd0 && rsp_tlast)
      else $error("malformed reset request");

   // Reset request never sits inside a read reply
   a_reply_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !rsp_tvalid || rsp_tuser == KIND_TX)
      else $error("reset request inside a read reply");

endmodule

bind serial_debug_memory_bridge sdmb_checker u_sdmb_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser),
   .rsp_tlast(rsp_tlast)
);

// File: tb/testbench.sv
// Self-checking testbench for the serial debug memory bridge.
`timescale 1ns / 100ps

import sdmb_pkg::*;

// Tracks the bridge state from accepted bytes and checks every reply transaction.
class bridge_scoreboard;
   typedef struct packed {
      logic kind;
      logic [7:0] tx_byte;
      logic last;
   } reply_item_type;

   logic [31:0] win_base;
   logic [7:0] hdr_byte;
   bit in_frame;
   logic [7:0] frame_buf[64];
   logic [5:0] frame_cnt;
   logic [7:0] window_mem[WIN_BYTES];
   reply_item_type pending_replies[$];
   int errors;

   function new();
      win_base = RESET_BASE;
      hdr_byte = RESET_HEADER;
      in_frame = 0;
      frame_cnt = '0;
      errors = 0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      foreach (window_mem[i]) window_mem[i] = '0;
   endfunction

   function void write_register(csr_index_type idx, logic [31:0] value);
      if (idx == CSR_WINDOW_BASE)
         win_base = value;
      else if (idx == CSR_HEADER_BYTE)
         hdr_byte = value[7:0];
   endfunction

   function int outstanding();
      return pending_replies.size();
   endfunction

   function logic [31:0] frame_address(int at);
      logic [31:0] a;
      a = '0;
      for (int i = 0; i < 4; i++)
         a[8*i +: 8] = frame_buf[at + i];
      return a;
   endfunction

   // Window memory byte at address a, zero outside the window
   function logic [7:0] window_read(logic [31:0] a);
      logic [31:0] off;
      off = a - win_base;
      if (off < WIN_BYTES)
         return window_mem[off];
      return 8'h00;
   endfunction

   function void complete_frame(logic [7:0] len);
      reply_item_type items[$];
      reply_item_type it;
      logic [7:0] cmd;
      logic [7:0] cnt;
      logic [31:0] a;
      logic [31:0] off;
      cmd = frame_buf[CMD_AT];
      if (cmd == CMD_READ) begin
         if (len < READ_MIN_LEN)
            return;
         cnt = frame_buf[BODY_AT];
         if (cnt > MAX_READ)
            cnt = 8'(MAX_READ);
         a = frame_address(BODY_AT + 1);
         it.kind = KIND_TX;
         it.last = 1'b0;
         it.tx_byte = hdr_byte;
         items.push_back(it);
         it.tx_byte = cnt + 8'(REPLY_HDR_LEN);
         items.push_back(it);
         it.tx_byte = 8'h00;
         items.push_back(it);
         for (int i = 0; i < cnt; i++) begin
            it.tx_byte = window_read(a + 32'(i));
            items.push_back(it);
         end
      end else if (cmd == CMD_WRITE) begin
         if (len < DATA_AT)
            return;
         a = frame_address(BODY_AT);
         for (int i = 0; i + DATA_AT < len; i++) begin
            off = a + 32'(i) - win_base;
            if (off < WIN_BYTES)
               window_mem[off] = frame_buf[DATA_AT + i];
         end
      end else if (cmd == CMD_RESET) begin
         it.kind = KIND_RESET;
         it.tx_byte = 8'h00;
         it.last = 1'b0;
         items.push_back(it);
      end
      if (items.size() > 0)
         items[items.size() - 1].last = 1'b1;
      foreach (items[i]) pending_replies.push_back(items[i]);
   endfunction

   function void note_rx_byte(logic [7:0] b);
      logic [7:0] len;
      if (!in_frame) begin
         if (b == hdr_byte) begin
            frame_buf[0] = b;
            frame_cnt = 6'd1;
            in_frame = 1;
         end
         return;
      end
      frame_buf[frame_cnt] = b;
      frame_cnt = frame_cnt + 6'd1;
      len = frame_buf[LEN_AT];
      if (frame_cnt == 6'd2) begin
         if (len < MIN_LEN || len > MAX_FRAME) begin
            in_frame = 0;
            frame_cnt = '0;
         end
         return;
      end
      if (8'(frame_cnt) >= len) begin
         in_frame = 0;
         frame_cnt = '0;
         complete_frame(len);
      end
   endfunction

   function void check_reply_item(logic kind, logic [7:0] tx_byte, logic last);
      reply_item_type exp_item;
      if (pending_replies.size() == 0) begin
         $error("unexpected reply: kind %0d tx_byte 0x%02h last %0d", kind, tx_byte, last);
         errors++;
         return;
      end
      exp_item = pending_replies.pop_front();
      if (kind !== exp_item.kind) begin
         $error("kind: expected %0d, got %0d", exp_item.kind, kind);
         errors++;
      end
      if (tx_byte !== exp_item.tx_byte) begin
         $error("tx_byte: expected 0x%02h, got 0x%02h", exp_item.tx_byte, tx_byte);
         errors++;
      end
      if (last !== exp_item.last) begin
         $error("last: expected %0d, got %0d", exp_item.last, last);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int SETTLE_CYCLES = 120;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   logic [31:0] csr_data;

   bridge_scoreboard sb;
   logic [7:0] pkt[$];
   logic [31:0] base_now;
   logic [7:0] hdr_now;
   bit no_idle;
   bit rx_started;

   serial_debug_memory_bridge dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Transaction monitor: feeds the scoreboard from every handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_reply_item(rsp_tuser, rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_rx_byte(req_tdata);
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_data);
      end
   end

   function automatic int draw_wait();
      if (no_idle)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   // Receiver: random stall before each reply transaction
   initial begin
      int stall;
      wait (rx_started);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_pkt();
      foreach (pkt[i]) send_byte(pkt[i]);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WINDOW_BASE)
         base_now = value;
      else
         hdr_now = value[7:0];
      @(posedge clock);
   endtask

   // Hold off the sender until every expected reply is in, then let a write walk finish
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_addr(input logic [31:0] a);
      for (int i = 0; i < 4; i++) pkt.push_back(a[8*i +: 8]);
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 5))
         0, 1: return base_now + 32'($urandom_range(0, 63));
         2: return base_now + WIN_BYTES - 32'($urandom_range(1, 20));
         3: return base_now - 32'($urandom_range(1, 10));
         4: return base_now + 32'($urandom_range(0, WIN_BYTES - 1));
         default: return $urandom();
      endcase
   endfunction

   function automatic void build_random_frame();
      int sel;
      int len;
      int cnt;
      bit bad_len;
      pkt.delete();
      bad_len = 0;
      sel = $urandom_range(0, 99);
      pkt.push_back(hdr_now);
      if (sel < 40) begin
         if ($urandom_range(0, 9) == 0)
            cnt = $urandom_range(0, 255);
         else if ($urandom_range(0, 3) == 0)
            cnt = $urandom_range(0, MAX_READ);
         else
            cnt = $urandom_range(1, 8);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(READ_MIN_LEN, MAX_FRAME)
                                           : READ_MIN_LEN;
         pkt.push_back(8'(len));
         pkt.push_back(CMD_READ);
         pkt.push_back(8'(cnt));
         push_addr(pick_addr());
      end else if (sel < 72) begin
         len = DATA_AT + (($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_FRAME - DATA_AT)
                                                      : $urandom_range(0, 6));
         pkt.push_back(8'(len));
         pkt.push_back(CMD_WRITE);
         push_addr(pick_addr());
      end else if (sel < 80) begin
         len = ($urandom_range(0, 2) == 0) ? $urandom_range(MIN_LEN, MAX_FRAME) : MIN_LEN;
         pkt.push_back(8'(len));
         pkt.push_back(CMD_RESET);
      end else if (sel < 87) begin
         // unknown command
         len = $urandom_range(MIN_LEN, MAX_FRAME);
         pkt.push_back(8'(len));
         pkt.push_back(8'($urandom_range(int'(CMD_RESET) + 1, 255)));
      end else if (sel < 93) begin
         // read frame that is too short to carry an address
         len = $urandom_range(MIN_LEN, READ_MIN_LEN - 1);
         pkt.push_back(8'(len));
         pkt.push_back(CMD_READ);
      end else begin
         bad_len = 1;
         len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, MIN_LEN - 1)
                                           : $urandom_range(MAX_FRAME + 1, 255);
         pkt.push_back(8'(len));
      end
      // write data, extra bytes and the body of unknown-command and short read frames are random
      if (!bad_len)
         while (pkt.size() < len) pkt.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic random_phase(input int target);
      int sent;
      int n_noise;
      sent = 0;
      while (sent < target) begin
         // line noise while hunting
         if ($urandom_range(0, 4) == 0) begin
            n_noise = $urandom_range(1, 3);
            repeat (n_noise) send_byte(hdr_now ^ 8'($urandom_range(1, 255)));
         end
         build_random_frame();
         send_pkt();
         sent += pkt.size();
      end
      drain_and_settle();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_WINDOW_BASE;
      csr_data = '0;
      base_now = RESET_BASE;
      hdr_now = RESET_HEADER;
      no_idle = 0;
      rx_started = 0;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      rx_started = 1;

      // Directed: noise, bad lengths, reset request, write then saturated read
      pkt = '{8'h00, 8'hFF,
              RESET_HEADER, 8'h02,
              RESET_HEADER, 8'hFF,
              RESET_HEADER, 8'h03, CMD_RESET,
              RESET_HEADER, 8'h08, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h20, 8'hFF,
              RESET_HEADER, 8'h08, CMD_READ, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h20};
      send_pkt();
      drain_and_settle();

      random_phase(45);

      write_csr(CSR_WINDOW_BASE, 32'h0000_0000);
      write_csr(CSR_HEADER_BYTE, 32'h0000_0000);
      random_phase(35);

      // window that wraps past the top of the address space
      write_csr(CSR_WINDOW_BASE, 32'hFFFF_FFF8);
      write_csr(CSR_HEADER_BYTE, 32'h0000_00FF);
      random_phase(35);

      write_csr(CSR_WINDOW_BASE, $urandom());
      write_csr(CSR_HEADER_BYTE, 32'($urandom_range(0, 255)));
      random_phase(35);

      write_csr(CSR_WINDOW_BASE, 32'(RESET_BASE));
      write_csr(CSR_HEADER_BYTE, 32'(RESET_HEADER));
      no_idle = 1;
      random_phase(30);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
design/sdmb_pkg.sv
design/sdmb_rx.sv
design/serial_debug_memory_bridge.sv
design/sdmb_checker.sv
tb/testbench.sv
